### sv/sab_pkg.sv
package sab_pkg;

   // field widths
   localparam int LEN_W      = 13;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = LEN_W;

   // sizes saturate here before use
   localparam int MAX_DIM = 4096;

   // divider operand widths: a cursor times a length over a length
   localparam int DIV_NUM_W = 2 * LEN_W;
   localparam int DIV_DEN_W = LEN_W;

   localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hFF00_0000;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_DATA  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SRC_LEFT   = 3'd0,
      CSR_SRC_TOP    = 3'd1,
      CSR_SRC_WIDTH  = 3'd2,
      CSR_SRC_HEIGHT = 3'd3,
      CSR_DST_LEFT   = 3'd4,
      CSR_DST_TOP    = 3'd5,
      CSR_DST_WIDTH  = 3'd6,
      CSR_DST_HEIGHT = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_STEP_X = 2'd0,
      DIV_STEP_Y = 2'd1,
      DIV_POS_X  = 2'd2,
      DIV_POS_Y  = 2'd3
   } div_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START_CHK,
      S_DATA_CHK,
      S_EMIT_WRITE,
      S_ADVANCE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT_READ,
      S_EMIT_DONE
   } state_type;

   typedef struct packed {
      action_type             action;
      logic [LEN_W-1:0]       surface_width;
      logic [LEN_W-1:0]       surface_height;
      logic [PIX_W-1:0]       pixel_color;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [COORD_W-1:0]     coord_x;
      logic [COORD_W-1:0]     coord_y;
      logic [PIX_W-1:0]       color;
      logic                   last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       start_take;
      logic       pix_take;
      logic       set_busy;
      logic       advance;
      logic       div_start;
      div_op_type div_op;
      logic       out_load;
      kind_type   out_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clip_zero;
      logic busy;
      logic alpha_set;
      logic finished;
      logic stale;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [LEN_W-1:0] sat_dim(input logic [LEN_W-1:0] v);
      return (v > LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM) : v;
   endfunction

   // length of a span that starts at origin, clipped to a surface
   function automatic logic [LEN_W-1:0] clip_len(input logic [COORD_W-1:0] origin,
                                                 input logic [LEN_W-1:0]   len,
                                                 input logic [LEN_W-1:0]   surf);
      logic [LEN_W-1:0] room;
      room = surf - LEN_W'(origin);
      if (LEN_W'(origin) >= surf) begin
         return '0;
      end
      return (len < room) ? len : room;
   endfunction

endpackage

### sv/sab_div.sv
module sab_div
   import sab_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one restoring step: bring down the next numerator bit
   assign trial = {rem_ff, acc_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         acc_in = {acc_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = acc_ff;
   assign rem  = rem_ff;

endmodule

### sv/sab_ctrl.sv
module sab_ctrl
   import sab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type  state_ff, state_in;
   div_op_type op_ff, op_in;
   logic       full_ff, full_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      full_in   = full_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_START) begin
                  cmd.start_take = 1'b1;
                  state_in       = S_START_CHK;
               end else if (status.busy) begin
                  cmd.pix_take = 1'b1;
                  state_in     = S_DATA_CHK;
               end
            end
         end
         S_START_CHK: begin
            if (status.clip_zero) begin
               state_in = S_EMIT_DONE;
            end else begin
               cmd.set_busy = 1'b1;
               op_in        = DIV_STEP_X;
               full_in      = 1'b0;
               state_in     = S_DIV_GO;
            end
         end
         S_DATA_CHK: begin
            state_in = status.alpha_set ? S_EMIT_WRITE : S_ADVANCE;
         end
         S_EMIT_WRITE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_WRITE;
               state_in     = S_ADVANCE;
            end
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            if (status.finished) begin
               state_in = S_EMIT_DONE;
            end else if (status.stale) begin
               // sizes changed mid-blit: redo steps and positions
               op_in    = DIV_STEP_X;
               full_in  = 1'b1;
               state_in = S_DIV_GO;
            end else begin
               state_in = S_EMIT_READ;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = op_ff;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            cmd.div_op = op_ff;
            if (status.div_done) begin
               case (op_ff)
                  DIV_STEP_X: begin
                     op_in    = DIV_STEP_Y;
                     state_in = S_DIV_GO;
                  end
                  DIV_STEP_Y: begin
                     if (full_ff) begin
                        op_in    = DIV_POS_X;
                        state_in = S_DIV_GO;
                     end else begin
                        state_in = S_EMIT_READ;
                     end
                  end
                  DIV_POS_X: begin
                     op_in    = DIV_POS_Y;
                     state_in = S_DIV_GO;
                  end
                  DIV_POS_Y: begin
                     state_in = S_EMIT_READ;
                  end
                  default: begin
                     state_in = S_EMIT_READ;
                  end
               endcase
            end
         end
         S_EMIT_READ: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_READ;
               state_in     = S_IDLE;
            end
         end
         S_EMIT_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_DONE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= DIV_STEP_X;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         full_ff  <= full_in;
      end
   end

endmodule

### sv/sab_dp.sv
module sab_dp
   import sab_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_type               req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   // configuration registers
   logic [COORD_W-1:0] src_left_ff, src_top_ff, dst_left_ff, dst_top_ff;
   logic [LEN_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic               stale_ff, stale_in;

   // blit state
   logic               busy_ff, busy_in;
   logic [LEN_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [LEN_W-1:0]   clip_w_ff, clip_w_in, clip_h_ff, clip_h_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;

   // scaled source offsets: quotient and remainder, plus per-step increments
   logic [LEN_W-1:0]   qx_ff, qx_in, rx_ff, rx_in, qy_ff, qy_in, ry_ff, ry_in;
   logic [LEN_W-1:0]   qsx_ff, qsx_in, rsx_ff, rsx_in, qsy_ff, qsy_in, rsy_ff, rsy_in;
   div_op_type         op_ff, op_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [LEN_W-1:0]   sw_src, sh_src, dw, dh;
   logic [LEN_W-1:0]   cx_next, cy_next;
   logic               wrap, finished;
   logic [LEN_W:0]     sum_x, sum_y;
   logic [LEN_W-1:0]   mul_a, mul_b;
   logic [DIV_NUM_W-1:0] prod, div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic               div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [DIV_DEN_W-1:0] div_rem;
   logic               out_free;

   assign sw_src = sat_dim(src_width_ff);
   assign sh_src = sat_dim(src_height_ff);
   assign dw     = sat_dim(dst_width_ff);
   assign dh     = sat_dim(dst_height_ff);

   // configuration writes; a size change flags the increments as stale
   always_ff @(posedge clock) begin
      if (reset) begin
         src_left_ff   <= '0;
         src_top_ff    <= '0;
         src_width_ff  <= '0;
         src_height_ff <= '0;
         dst_left_ff   <= '0;
         dst_top_ff    <= '0;
         dst_width_ff  <= '0;
         dst_height_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_SRC_LEFT:   src_left_ff   <= csr_wdata[COORD_W-1:0];
            CSR_SRC_TOP:    src_top_ff    <= csr_wdata[COORD_W-1:0];
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_LEFT:   dst_left_ff   <= csr_wdata[COORD_W-1:0];
            CSR_DST_TOP:    dst_top_ff    <= csr_wdata[COORD_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stale_in = stale_ff;
      if (cmd.start_take || (cmd.div_start && cmd.div_op == DIV_STEP_X)) begin
         stale_in = 1'b0;
      end
      if (csr_wr_en && (csr_index_type'(csr_addr) == CSR_SRC_WIDTH ||
                        csr_index_type'(csr_addr) == CSR_SRC_HEIGHT ||
                        csr_index_type'(csr_addr) == CSR_DST_WIDTH ||
                        csr_index_type'(csr_addr) == CSR_DST_HEIGHT)) begin
         stale_in = 1'b1;
      end
   end

   // cursor walk
   assign cx_next  = cx_ff + LEN_W'(1);
   assign wrap     = (cx_next >= clip_w_ff);
   assign cy_next  = wrap ? cy_ff + LEN_W'(1) : cy_ff;
   assign finished = (cy_next >= clip_h_ff);

   // incremental floor(cur * src / dst): remainders stay below dst
   assign sum_x = {1'b0, rx_ff} + {1'b0, rsx_ff};
   assign sum_y = {1'b0, ry_ff} + {1'b0, rsy_ff};

   // divider operands
   assign mul_a   = (cmd.div_op == DIV_POS_X) ? cx_ff : cy_ff;
   assign mul_b   = (cmd.div_op == DIV_POS_X) ? sw_src : sh_src;
   assign prod    = DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b);
   assign div_num = (cmd.div_op == DIV_STEP_X) ? DIV_NUM_W'(sw_src) :
                    (cmd.div_op == DIV_STEP_Y) ? DIV_NUM_W'(sh_src) : prod;
   assign div_den = (cmd.div_op == DIV_STEP_X || cmd.div_op == DIV_POS_X) ? dw : dh;

   sab_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // blit state update
   always_comb begin
      busy_in   = busy_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      clip_w_in = clip_w_ff;
      clip_h_in = clip_h_ff;
      pix_in    = pix_ff;
      qx_in     = qx_ff;
      rx_in     = rx_ff;
      qy_in     = qy_ff;
      ry_in     = ry_ff;
      qsx_in    = qsx_ff;
      rsx_in    = rsx_ff;
      qsy_in    = qsy_ff;
      rsy_in    = rsy_ff;
      op_in     = op_ff;

      if (cmd.start_take) begin
         busy_in   = 1'b0;
         cx_in     = '0;
         cy_in     = '0;
         qx_in     = '0;
         rx_in     = '0;
         qy_in     = '0;
         ry_in     = '0;
         clip_w_in = clip_len(dst_left_ff, dw, sat_dim(req_data.surface_width));
         clip_h_in = clip_len(dst_top_ff, dh, sat_dim(req_data.surface_height));
      end
      if (cmd.set_busy) begin
         busy_in = 1'b1;
      end
      if (cmd.pix_take) begin
         pix_in = req_data.pixel_color;
      end

      if (cmd.advance) begin
         if (finished) begin
            cx_in = '0;
            cy_in = '0;
         end else if (wrap) begin
            cx_in = '0;
            qx_in = '0;
            rx_in = '0;
            cy_in = cy_next;
            if (sum_y >= {1'b0, dh}) begin
               ry_in = LEN_W'(sum_y - {1'b0, dh});
               qy_in = qy_ff + qsy_ff + LEN_W'(1);
            end else begin
               ry_in = sum_y[LEN_W-1:0];
               qy_in = qy_ff + qsy_ff;
            end
         end else begin
            cx_in = cx_next;
            if (sum_x >= {1'b0, dw}) begin
               rx_in = LEN_W'(sum_x - {1'b0, dw});
               qx_in = qx_ff + qsx_ff + LEN_W'(1);
            end else begin
               rx_in = sum_x[LEN_W-1:0];
               qx_in = qx_ff + qsx_ff;
            end
         end
      end

      // capture divider results by the operation that was issued
      if (cmd.div_start) begin
         op_in = cmd.div_op;
      end
      if (div_done) begin
         case (op_ff)
            DIV_STEP_X: begin
               qsx_in = div_quo[LEN_W-1:0];
               rsx_in = div_rem;
            end
            DIV_STEP_Y: begin
               qsy_in = div_quo[LEN_W-1:0];
               rsy_in = div_rem;
            end
            DIV_POS_X: begin
               qx_in = div_quo[LEN_W-1:0];
               rx_in = div_rem;
            end
            DIV_POS_Y: begin
               qy_in = div_quo[LEN_W-1:0];
               ry_in = div_rem;
            end
            default: begin
            end
         endcase
      end

      if (cmd.out_load && cmd.out_kind == KIND_DONE) begin
         busy_in = 1'b0;
         cx_in   = '0;
         cy_in   = '0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_in.kind    = cmd.out_kind;
         rsp_in.coord_x = '0;
         rsp_in.coord_y = '0;
         rsp_in.color   = '0;
         rsp_in.last    = 1'b1;
         case (cmd.out_kind)
            KIND_READ: begin
               rsp_in.coord_x = qx_ff[COORD_W-1:0] + src_left_ff;
               rsp_in.coord_y = qy_ff[COORD_W-1:0] + src_top_ff;
            end
            KIND_WRITE: begin
               rsp_in.coord_x = cx_ff[COORD_W-1:0] + dst_left_ff;
               rsp_in.coord_y = cy_ff[COORD_W-1:0] + dst_top_ff;
               rsp_in.color   = pix_ff;
               rsp_in.last    = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         clip_w_ff    <= '0;
         clip_h_ff    <= '0;
         op_ff        <= DIV_STEP_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         stale_ff     <= stale_in;
         busy_ff      <= busy_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         clip_w_ff    <= clip_w_in;
         clip_h_ff    <= clip_h_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff <= pix_in;
      qx_ff  <= qx_in;
      rx_ff  <= rx_in;
      qy_ff  <= qy_in;
      ry_ff  <= ry_in;
      qsx_ff <= qsx_in;
      rsx_ff <= rsx_in;
      qsy_ff <= qsy_in;
      rsy_ff <= rsy_in;
      rsp_ff <= rsp_in;
   end

   assign status.clip_zero = (clip_w_ff == '0) || (clip_h_ff == '0);
   assign status.busy      = busy_ff;
   assign status.alpha_set = ((pix_ff & ALPHA_MASK) != '0);
   assign status.finished  = finished;
   assign status.stale     = stale_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/scaled_alpha_blit_engine.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_data  (start or source pixel data)
// rsp       out        rsp_valid/rsp_stall  rsp_data  (source read, write or done)
// csr       in         csr_wr_en            csr_addr, csr_wdata
//
// A data request is accepted, alpha-tested, written when its alpha is set, has its cursor
// stepped and then issues a read or done. A start runs two divisions for the scale
// increments on the one-bit-a-cycle divider, each with issue and wait, or none when clipped
// away; after a size register change in a blit the next pixel redoes four divisions.
// Reset is synchronous, with no clearing pass. req_stall is high while a request is in work;
// rsp_stall holds the output register.
module scaled_alpha_blit_engine
   import sab_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   sab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   sab_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
